// File: hw/rtl/eas_pkg.sv
// Shared types, constants and lookup tables for the encoder setpoint adjuster.
// No dependencies; every other file of the block imports this package.
package eas_pkg;

  localparam int unsigned SetpointW  = 16;
  localparam int unsigned StepW      = 10;
  localparam int unsigned IntervalW  = 32;
  localparam int unsigned OpW        = 2;
  localparam int unsigned NumSetpt   = 4;
  localparam int unsigned SetptIdxW  = 2;
  localparam int unsigned NumThresh  = 32;
  localparam int unsigned FifoDepth  = 2;

  // Input operation codes
  localparam logic [OpW-1:0] OP_LEFT    = 2'd0;
  localparam logic [OpW-1:0] OP_RIGHT   = 2'd1;
  localparam logic [OpW-1:0] OP_ADVANCE = 2'd2;

  // Limit register indexes and reset values
  localparam logic [SetptIdxW-1:0] REG_CH0_VOLT = 2'd0;
  localparam logic [SetptIdxW-1:0] REG_CH0_CURR = 2'd1;
  localparam logic [SetptIdxW-1:0] REG_CH1_VOLT = 2'd2;
  localparam logic [SetptIdxW-1:0] REG_CH1_CURR = 2'd3;

  localparam logic [SetpointW-1:0] VOLT_LIMIT_RST = 16'd28500;
  localparam logic [SetpointW-1:0] CURR_LIMIT_RST = 16'd2048;

  // Descending interval thresholds; the first one reached picks the step
  localparam logic [SetpointW-1:0] THRESH_TAB [NumThresh] = '{
    16'd65051, 16'd54845, 16'd47930, 16'd42693, 16'd38477, 16'd34948, 16'd31913, 16'd29251,
    16'd26880, 16'd24742, 16'd22796, 16'd21010, 16'd19360, 16'd17827, 16'd16395, 16'd15051,
    16'd13786, 16'd12590, 16'd11457, 16'd10380, 16'd9354,  16'd8374,  16'd7437,  16'd6538,
    16'd5675,  16'd4845,  16'd4046,  16'd3275,  16'd2530,  16'd1810,  16'd1113,  16'd500
  };

  localparam logic [StepW-1:0] STEP_TAB [NumThresh] = '{
    10'd1,   10'd1,   10'd1,   10'd20,  10'd55,  10'd90,  10'd125, 10'd160,
    10'd195, 10'd230, 10'd265, 10'd300, 10'd335, 10'd370, 10'd405, 10'd440,
    10'd475, 10'd510, 10'd545, 10'd580, 10'd615, 10'd650, 10'd685, 10'd720,
    10'd755, 10'd790, 10'd825, 10'd860, 10'd895, 10'd930, 10'd965, 10'd1000
  };

  // What the back end has to do with one word
  typedef enum logic [1:0] {
    KIND_DEC = 2'd0,
    KIND_INC = 2'd1,
    KIND_ADV = 2'd2,
    KIND_NOP = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [StepW-1:0]  step;
  } cmd_t;

endpackage

// File: hw/rtl/encoder_accelerated_setpoint_adjust_top.sv
// Encoder setpoint adjuster with speed-dependent step size.
// Input channel (in_valid_i / in_stall_o) carries one encoder event per word:
//   operation_i selects rotate left, rotate right or advance selection, and
//   interval_i gives the time since the previous detent.
// Output channel (out_valid_o / out_stall_i) returns one word per event with
//   the selection, the selected setpoint, the step applied and a clamp flag.
// A word moves when valid is high and stall is low at a rising clock edge.
// The input word is registered in the queue and then in the output register,
//   which the back end loads only while it is empty or being drained.
// Throughput: one word per cycle unless stalled; the front end looks up the
//   step with 32 parallel threshold compares, the back end does one add or
//   subtract and a limit compare per word, with a FifoDepth-word queue between.
// Limit registers are written through cfg_we_i / cfg_index_i / cfg_data_i;
//   the user must write them only while no word is in flight, unchecked by the block.
// Reset (rst_ni low) clears all setpoints, selects channel 0 voltage, loads
//   the default limits and empties the queue and the output register.
// When the receiver stalls, the output word holds; the queue then fills and
//   in_stall_o rises once it is full.
// Depends on eas_pkg, eas_front, eas_queue and eas_back.
module encoder_accelerated_setpoint_adjust_top #(
  parameter int unsigned FifoDepth = eas_pkg::FifoDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [eas_pkg::SetptIdxW-1:0]   cfg_index_i,
  input  logic [eas_pkg::SetpointW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [eas_pkg::OpW-1:0]         operation_i,
  input  logic [eas_pkg::IntervalW-1:0]   interval_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            sel_channel_o,
  output logic                            sel_quantity_o,
  output logic [eas_pkg::SetpointW-1:0]   setpoint_value_o,
  output logic [eas_pkg::StepW-1:0]       step_used_o,
  output logic                            hit_limit_o
);
  import eas_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full, q_valid, q_pop;

  assign in_stall_o = q_full;

  eas_front u_front (
    .operation_i (operation_i),
    .interval_i  (interval_i),
    .cmd_o       (front_cmd)
  );

  eas_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (head_cmd)
  );

  eas_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_valid_i      (q_valid),
    .cmd_i            (head_cmd),
    .cmd_pop_o        (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sel_channel_o    (sel_channel_o),
    .sel_quantity_o   (sel_quantity_o),
    .setpoint_value_o (setpoint_value_o),
    .step_used_o      (step_used_o),
    .hit_limit_o      (hit_limit_o)
  );

endmodule

// File: hw/rtl/eas_front.sv
// Front end: classifies an incoming word and looks up its step size.
// Depends on eas_pkg for the threshold and step tables and the command type.
module eas_front (
  input  logic [eas_pkg::OpW-1:0]       operation_i,
  input  logic [eas_pkg::IntervalW-1:0] interval_i,
  output eas_pkg::cmd_t                 cmd_o
);
  import eas_pkg::*;

  logic [StepW-1:0] step;

  // Priority search: the lowest-numbered threshold reached wins
  always_comb begin
    step = '0;
    for (int i = NumThresh - 1; i >= 0; i--) begin
      if (interval_i >= IntervalW'(THRESH_TAB[i])) begin
        step = STEP_TAB[i];
      end
    end
  end

  always_comb begin
    cmd_o.kind = KIND_NOP;
    cmd_o.step = '0;
    case (operation_i)
      OP_LEFT: begin
        if (step != '0) begin
          cmd_o.kind = KIND_DEC;
          cmd_o.step = step;
        end
      end
      OP_RIGHT: begin
        if (step != '0) begin
          cmd_o.kind = KIND_INC;
          cmd_o.step = step;
        end
      end
      OP_ADVANCE: begin
        cmd_o.kind = KIND_ADV;
      end
      default: begin
        cmd_o.kind = KIND_NOP;
      end
    endcase
  end

endmodule

// File: hw/rtl/eas_queue.sv
// Short command queue between the front and back ends.
// Depends on eas_pkg for the command type.
module eas_queue #(
  parameter int unsigned Depth = eas_pkg::FifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  eas_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output eas_pkg::cmd_t pop_data_o
);
  import eas_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t              mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/eas_back.sv
// Back end: holds setpoints, limits and selection, applies commands, drives the
// output register. Depends on eas_pkg for the command type and constants.
module eas_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [eas_pkg::SetptIdxW-1:0]   cfg_index_i,
  input  logic [eas_pkg::SetpointW-1:0]   cfg_data_i,
  input  logic                            cmd_valid_i,
  input  eas_pkg::cmd_t                   cmd_i,
  output logic                            cmd_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            sel_channel_o,
  output logic                            sel_quantity_o,
  output logic [eas_pkg::SetpointW-1:0]   setpoint_value_o,
  output logic [eas_pkg::StepW-1:0]       step_used_o,
  output logic                            hit_limit_o
);
  import eas_pkg::*;

  logic [SetpointW-1:0] setpt_q [NumSetpt];
  logic [SetpointW-1:0] limit_q [NumSetpt];
  logic                 sel_ch_q, sel_ch_d;
  logic                 sel_qty_q, sel_qty_d;
  logic [SetptIdxW-1:0] idx;
  logic [SetpointW-1:0] rd_val, rd_lim, new_val;
  logic [SetpointW:0]   sum;
  logic                 hit, wr_setpt;
  logic                 out_valid_q;
  logic                 pop;

  // Take a word when the output register is empty or being drained
  assign pop       = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = pop;

  always_comb begin
    sel_ch_d  = sel_ch_q;
    sel_qty_d = sel_qty_q;
    if (cmd_i.kind == KIND_ADV) begin
      if (!sel_qty_q) begin
        sel_qty_d = 1'b1;
      end else begin
        sel_qty_d = 1'b0;
        sel_ch_d  = ~sel_ch_q;
      end
    end
  end

  // Rotates leave the selection alone, so one read index serves all cases
  assign idx    = {sel_ch_d, sel_qty_d};
  assign rd_val = setpt_q[idx];
  assign rd_lim = limit_q[idx];
  assign sum    = {1'b0, rd_val} + (SetpointW + 1)'(cmd_i.step);

  always_comb begin
    new_val  = rd_val;
    hit      = 1'b0;
    wr_setpt = 1'b0;
    case (cmd_i.kind)
      KIND_DEC: begin
        wr_setpt = 1'b1;
        if (rd_val < SetpointW'(cmd_i.step)) begin
          new_val = '0;
          hit     = 1'b1;
        end else begin
          new_val = rd_val - SetpointW'(cmd_i.step);
        end
      end
      KIND_INC: begin
        wr_setpt = 1'b1;
        if (sum > {1'b0, rd_lim}) begin
          new_val = rd_lim;
          hit     = 1'b1;
        end else begin
          new_val = sum[SetpointW-1:0];
        end
      end
      default: begin
        new_val = rd_val;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSetpt; i++) begin
        setpt_q[i] <= '0;
      end
      limit_q[REG_CH0_VOLT] <= VOLT_LIMIT_RST;
      limit_q[REG_CH0_CURR] <= CURR_LIMIT_RST;
      limit_q[REG_CH1_VOLT] <= VOLT_LIMIT_RST;
      limit_q[REG_CH1_CURR] <= CURR_LIMIT_RST;
      sel_ch_q    <= 1'b0;
      sel_qty_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q[cfg_index_i] <= cfg_data_i;
      end
      if (pop) begin
        sel_ch_q  <= sel_ch_d;
        sel_qty_q <= sel_qty_d;
        if (wr_setpt) begin
          setpt_q[idx] <= new_val;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      sel_channel_o    <= sel_ch_d;
      sel_quantity_o   <= sel_qty_d;
      setpoint_value_o <= new_val;
      step_used_o      <= cmd_i.step;
      hit_limit_o      <= hit;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
